FILE: rtl/core/ptcp_pkg.sv
// ----------------------------------------------------------------------------
// ptcp_pkg
// Shared types and constants of the pulse train chunk packer: pulse command
// passed from front to back, result item, and chunk limits.
// ----------------------------------------------------------------------------
package ptcp_pkg;

   // field widths
   localparam int unsigned DUR_W   = 16;
   localparam int unsigned CHUNK_W = 15;

   // longest chunk in ticks, and the clamp on one pulse (three chunks)
   localparam int unsigned MAX_CHUNK = 32767;
   localparam logic [DUR_W:0] PULSE_CAP = (DUR_W + 1)'(3 * MAX_CHUNK);

   // default queue depths
   localparam int unsigned CMD_DEPTH_DEF = 2;
   localparam int unsigned RSP_DEPTH_DEF = 2;

   // one classified pulse, as the back part consumes it
   typedef struct packed {
      logic             level;
      logic [DUR_W-1:0] duration;
      logic             last;
   } cmd_type;

   // one packed two-half result item
   typedef struct packed {
      logic               first_level;
      logic [CHUNK_W-1:0] first_duration;
      logic               second_level;
      logic [CHUNK_W-1:0] second_duration;
      logic               last_item;
   } item_type;

endpackage

FILE: rtl/core/ptcp_fifo.sv
// ----------------------------------------------------------------------------
// ptcp_fifo
// Small register queue with push/full and pop/empty sides; the head entry is
// shown on rd_data while empty is low.
// ----------------------------------------------------------------------------
module ptcp_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/core/ptcp_front.sv
// ----------------------------------------------------------------------------
// ptcp_front
// Accepts pulse requests, tracks the train and its alternating level, cleans
// up the duration (zero to one, clamp to three chunks) and issues commands.
// ----------------------------------------------------------------------------
module ptcp_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data,
   input  logic                      req_accept,
   input  logic [ptcp_pkg::DUR_W-1:0] req_pulse_duration,
   input  logic                      req_last_pulse,
   output ptcp_pkg::cmd_type         cmd_data
);

   logic                       start_level_ff;
   logic                       level_ff;
   logic                       level_in;
   logic                       in_train_ff;
   logic                       in_train_in;
   logic                       pulse_level;
   logic [ptcp_pkg::DUR_W-1:0] dur_nz;
   logic [ptcp_pkg::DUR_W-1:0] dur_eff;

   // pick the level: a new train starts at the configured level
   assign pulse_level = in_train_ff ? level_ff : start_level_ff;
   assign level_in    = ~pulse_level;
   assign in_train_in = ~req_last_pulse;

   // zero counts as one tick; clamp so at most three chunks arise
   always_comb begin
      dur_nz = (req_pulse_duration == '0) ? ptcp_pkg::DUR_W'(1) : req_pulse_duration;
      dur_eff = dur_nz;
      if ({1'b0, dur_nz} > ptcp_pkg::PULSE_CAP) begin
         dur_eff = ptcp_pkg::PULSE_CAP[ptcp_pkg::DUR_W-1:0];
      end
   end

   assign cmd_data.level    = pulse_level;
   assign cmd_data.duration = dur_eff;
   assign cmd_data.last     = req_last_pulse;

   // hold the configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         start_level_ff <= 1'b1;
      end else if (csr_wr_en) begin
         start_level_ff <= csr_wr_data;
      end
   end

   // advance the train state per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= 1'b0;
         in_train_ff <= 1'b0;
      end else if (req_accept) begin
         level_ff    <= level_in;
         in_train_ff <= in_train_in;
      end
   end

endmodule

FILE: rtl/core/ptcp_back.sv
// ----------------------------------------------------------------------------
// ptcp_back
// Cuts each pulse command into chunks, one per cycle unless a due item meets a
// full result queue, and pairs them into two-half result items, holding an odd chunk over.
// ----------------------------------------------------------------------------
module ptcp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_empty,
   input  ptcp_pkg::cmd_type   cmd_data,
   output logic                cmd_pop,
   input  logic                item_full,
   output logic                item_push,
   output ptcp_pkg::item_type  item_data
);

   localparam logic [ptcp_pkg::DUR_W-1:0] MAX_DUR = ptcp_pkg::DUR_W'(ptcp_pkg::MAX_CHUNK);

   logic                         busy_ff;
   logic                         busy_in;
   logic [ptcp_pkg::DUR_W-1:0]   rem_ff;
   logic [ptcp_pkg::DUR_W-1:0]   rem_in;
   logic                         level_ff;
   logic                         last_ff;
   logic                         pend_valid_ff;
   logic                         pend_valid_in;
   logic                         pend_level_ff;
   logic [ptcp_pkg::CHUNK_W-1:0] pend_dur_ff;

   logic                         active;
   logic                         src_level;
   logic                         src_last;
   logic [ptcp_pkg::DUR_W-1:0]   src_rem;
   logic [ptcp_pkg::DUR_W-1:0]   chunk;
   logic                         final_chunk;
   logic                         emit;
   logic                         step;

   // work from the queue head on the first chunk, from registers after that
   assign active    = busy_ff | ~cmd_empty;
   assign src_rem   = busy_ff ? rem_ff   : cmd_data.duration;
   assign src_level = busy_ff ? level_ff : cmd_data.level;
   assign src_last  = busy_ff ? last_ff  : cmd_data.last;

   // take one chunk off the pulse
   assign chunk       = (src_rem > MAX_DUR) ? MAX_DUR : src_rem;
   assign rem_in      = src_rem - chunk;
   assign final_chunk = (rem_in == '0);

   // an item goes out when a chunk pairs up, or on the train's final chunk
   assign emit    = pend_valid_ff | (final_chunk & src_last);
   assign step    = active & (~emit | ~item_full);
   assign cmd_pop = step & ~busy_ff;
   assign busy_in = ~final_chunk;
   assign item_push = step & emit;
   assign pend_valid_in = ~emit;

   // build the item from the held chunk and the new one
   always_comb begin
      if (pend_valid_ff) begin
         item_data.first_level     = pend_level_ff;
         item_data.first_duration  = pend_dur_ff;
         item_data.second_level    = src_level;
         item_data.second_duration = chunk[ptcp_pkg::CHUNK_W-1:0];
         item_data.last_item       = final_chunk & src_last;
      end else begin
         item_data.first_level     = src_level;
         item_data.first_duration  = chunk[ptcp_pkg::CHUNK_W-1:0];
         item_data.second_level    = 1'b0;
         item_data.second_duration = '0;
         item_data.last_item       = 1'b1;
      end
   end

   // advance the chunk sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else if (step) begin
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // hold the pulse remainder and the odd chunk
   always_ff @(posedge clock) begin
      if (step) begin
         rem_ff   <= rem_in;
         level_ff <= src_level;
         last_ff  <= src_last;
         if (!emit) begin
            pend_level_ff <= src_level;
            pend_dur_ff   <= chunk[ptcp_pkg::CHUNK_W-1:0];
         end
      end
   end

   // a pulse in progress always has ticks left
   a_busy_rem: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff != '0)
      else $error("chunk sequencer busy with no ticks left");

   // a train's final chunk leaves nothing held over
   a_flush: assert property (@(posedge clock) disable iff (reset)
      (step && final_chunk && src_last) |=> !pend_valid_ff && !busy_ff)
      else $error("held chunk survived the end of a train");

   // every item carries a nonempty first half
   a_first_nonzero: assert property (@(posedge clock) disable iff (reset)
      item_push |-> item_data.first_duration != '0)
      else $error("item with empty first half");

   // an empty second half appears only on the train's last item
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (item_push && item_data.second_duration == '0) |-> item_data.last_item)
      else $error("single-chunk item not marked last");

endmodule

FILE: rtl/core/pulse_train_chunk_packer.sv
// ----------------------------------------------------------------------------
// pulse_train_chunk_packer
// Splits a train of pulse durations into chunks and packs them in pairs into
// two-half level/duration items.
// ----------------------------------------------------------------------------
// Path: an accepted request is registered in the command queue; the back part
//   cuts its chunks from the queue head and writes each finished item into the
//   result queue, whose head entry is shown on the rsp_ ports while empty is low.
// Throughput: the back part cuts one chunk per cycle, stalling while an item is due
//   and the result queue is full; ceil(duration / MAX_CHUNK) chunks per pulse, one to three (two or fewer below 65535).
// Reset: synchronous; empties both queues, ends any train, start_level = 1.
// ----------------------------------------------------------------------------
module pulse_train_chunk_packer #(
   parameter int unsigned CMD_DEPTH = ptcp_pkg::CMD_DEPTH_DEF,
   parameter int unsigned RSP_DEPTH = ptcp_pkg::RSP_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   input  logic                          push,
   output logic                          full,
   input  logic [ptcp_pkg::DUR_W-1:0]    req_pulse_duration,
   input  logic                          req_last_pulse,
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_first_level,
   output logic [ptcp_pkg::CHUNK_W-1:0]  rsp_first_duration,
   output logic                          rsp_second_level,
   output logic [ptcp_pkg::CHUNK_W-1:0]  rsp_second_duration,
   output logic                          rsp_last_item
);

   localparam int unsigned CMD_W  = $bits(ptcp_pkg::cmd_type);
   localparam int unsigned ITEM_W = $bits(ptcp_pkg::item_type);

   logic               req_accept;
   ptcp_pkg::cmd_type  front_cmd;
   ptcp_pkg::cmd_type  head_cmd;
   logic [CMD_W-1:0]   head_cmd_bits;
   logic               cmd_empty;
   logic               cmd_pop;
   logic               item_full;
   logic               item_push;
   ptcp_pkg::item_type item_data;
   ptcp_pkg::item_type rsp_item;
   logic [ITEM_W-1:0]  rsp_item_bits;

   assign req_accept = push & ~full;

   // classify requests
   ptcp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_accept         (req_accept),
      .req_pulse_duration (req_pulse_duration),
      .req_last_pulse     (req_last_pulse),
      .cmd_data           (front_cmd)
   );

   // decouple front and back
   ptcp_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (front_cmd),
      .full    (full),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .rd_data (head_cmd_bits)
   );

   assign head_cmd = ptcp_pkg::cmd_type'(head_cmd_bits);

   // chunk and pair
   ptcp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (head_cmd),
      .cmd_pop   (cmd_pop),
      .item_full (item_full),
      .item_push (item_push),
      .item_data (item_data)
   );

   // hold finished items for the consumer
   ptcp_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (item_push),
      .wr_data (item_data),
      .full    (item_full),
      .pop     (pop),
      .empty   (empty),
      .rd_data (rsp_item_bits)
   );

   assign rsp_item            = ptcp_pkg::item_type'(rsp_item_bits);
   assign rsp_first_level     = rsp_item.first_level;
   assign rsp_first_duration  = rsp_item.first_duration;
   assign rsp_second_level    = rsp_item.second_level;
   assign rsp_second_duration = rsp_item.second_duration;
   assign rsp_last_item       = rsp_item.last_item;

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pulse_train_chunk_packer. A short stimulus table
// (extremes, zero duration, odd leftovers, start level changes inside and
// between trains) runs first, followed by random pulse trains. Each accepted
// request is run through a local chunk/pair predictor and every popped item
// is compared field by field with the oldest expected item. Both sides idle
// in random bursts; the receiver also holds off once long enough to fill the
// block.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE       = 8;
   localparam int LONG_HOLD    = 300;
   localparam int N_PHASES     = 6;
   localparam int PHASE_PULSES = 200;
   localparam int PREDICT      = -1;
   localparam ptcp_pkg::item_type NO_ITEM = '0;

   typedef enum logic {ROW_PULSE, ROW_CFG} row_kind_type;

   // one row of the directed table: a pulse, or a start level write
   typedef struct {
      row_kind_type                kind;
      logic [ptcp_pkg::DUR_W-1:0]  value;
      logic                        last;
      int                          n_typed;
      ptcp_pkg::item_type          first_item;
      ptcp_pkg::item_type          second_item;
   } plan_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_wr_en = 1'b0;
   logic                          csr_wr_data = 1'b0;
   logic                          push = 1'b0;
   logic                          full;
   logic [ptcp_pkg::DUR_W-1:0]    req_pulse_duration = '0;
   logic                          req_last_pulse = 1'b0;
   logic                          empty;
   logic                          pop = 1'b0;
   logic                          rsp_first_level;
   logic [ptcp_pkg::CHUNK_W-1:0]  rsp_first_duration;
   logic                          rsp_second_level;
   logic [ptcp_pkg::CHUNK_W-1:0]  rsp_second_duration;
   logic                          rsp_last_item;

   // predictor state
   logic                          start_level_q = 1'b1;
   logic                          level_q = 1'b0;
   logic                          train_open = 1'b0;
   logic                          held_valid = 1'b0;
   logic                          held_level = 1'b0;
   logic [ptcp_pkg::CHUNK_W-1:0]  held_dur = '0;
   ptcp_pkg::item_type            packed_items [2];
   ptcp_pkg::item_type            expected_items [$];

   // run bookkeeping
   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  pulses_sent = 0;
   int                  trains_closed = 0;
   int                  items_checked = 0;
   int                  full_cycles = 0;
   int                  hold_asks = 0;
   logic                quiet_tail = 1'b0;

   plan_row_type plan [21] = '{
      '{ROW_PULSE, 16'd0,     1'b1, 1, '{1'b1, 15'd1, 1'b0, 15'd0, 1'b1}, NO_ITEM},
      '{ROW_PULSE, 16'd65535, 1'b1, 2, '{1'b1, 15'd32767, 1'b1, 15'd32767, 1'b0},
                                       '{1'b1, 15'd1, 1'b0, 15'd0, 1'b1}},
      '{ROW_PULSE, 16'd32767, 1'b1, 1, '{1'b1, 15'd32767, 1'b0, 15'd0, 1'b1}, NO_ITEM},
      '{ROW_PULSE, 16'd32768, 1'b1, 1, '{1'b1, 15'd32767, 1'b1, 15'd1, 1'b1}, NO_ITEM},
      '{ROW_PULSE, 16'd1,     1'b0, 0, NO_ITEM, NO_ITEM},
      '{ROW_PULSE, 16'd2,     1'b0, PREDICT, NO_ITEM, NO_ITEM},
      '{ROW_PULSE, 16'd65535, 1'b0, PREDICT, NO_ITEM, NO_ITEM},
      '{ROW_PULSE, 16'd0,     1'b1, PREDICT, NO_ITEM, NO_ITEM},
      '{ROW_PULSE, 16'hAAAA,  1'b0, PREDICT, NO_ITEM, NO_ITEM},
      '{ROW_PULSE, 16'h5555,  1'b1, PREDICT, NO_ITEM, NO_ITEM},
      '{ROW_CFG,   16'd0,     1'b0, PREDICT, NO_ITEM, NO_ITEM},
      '{ROW_PULSE, 16'd0,     1'b1, 1, '{1'b0, 15'd1, 1'b0, 15'd0, 1'b1}, NO_ITEM},
      '{ROW_PULSE, 16'd65535, 1'b1, 2, '{1'b0, 15'd32767, 1'b0, 15'd32767, 1'b0},
                                       '{1'b0, 15'd1, 1'b0, 15'd0, 1'b1}},
      '{ROW_PULSE, 16'd5,     1'b0, 0, NO_ITEM, NO_ITEM},
      '{ROW_CFG,   16'd1,     1'b0, PREDICT, NO_ITEM, NO_ITEM},
      '{ROW_PULSE, 16'd7,     1'b1, 1, '{1'b0, 15'd5, 1'b1, 15'd7, 1'b1}, NO_ITEM},
      '{ROW_PULSE, 16'd3,     1'b1, 1, '{1'b1, 15'd3, 1'b0, 15'd0, 1'b1}, NO_ITEM},
      '{ROW_PULSE, 16'd32767, 1'b0, PREDICT, NO_ITEM, NO_ITEM},
      '{ROW_PULSE, 16'd32767, 1'b0, PREDICT, NO_ITEM, NO_ITEM},
      '{ROW_PULSE, 16'd1,     1'b0, PREDICT, NO_ITEM, NO_ITEM},
      '{ROW_PULSE, 16'd65534, 1'b1, PREDICT, NO_ITEM, NO_ITEM}
   };

   pulse_train_chunk_packer u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .push                (push),
      .full                (full),
      .req_pulse_duration  (req_pulse_duration),
      .req_last_pulse      (req_last_pulse),
      .empty               (empty),
      .pop                 (pop),
      .rsp_first_level     (rsp_first_level),
      .rsp_first_duration  (rsp_first_duration),
      .rsp_second_level    (rsp_second_level),
      .rsp_second_duration (rsp_second_duration),
      .rsp_last_item       (rsp_last_item)
   );

   always #5 clock = ~clock;

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d items outstanding", $time,
                  expected_items.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // cut one pulse into chunks and pair them; fills packed_items
   task automatic pack_pulse(input logic [ptcp_pkg::DUR_W-1:0] dur_in, input logic last,
                             output int count);
      logic [ptcp_pkg::DUR_W:0]      left;
      logic [ptcp_pkg::CHUNK_W-1:0]  chunk;
      logic                          lv [4];
      logic [ptcp_pkg::CHUNK_W-1:0]  du [4];
      int                            n;
      int                            i;
      left = (dur_in == '0) ? (ptcp_pkg::DUR_W + 1)'(1) : {1'b0, dur_in};
      if (left > ptcp_pkg::PULSE_CAP)
         left = ptcp_pkg::PULSE_CAP;
      n = 0;
      count = 0;
      // a new train takes its level from the register
      if (!train_open) begin
         level_q = start_level_q;
         train_open = 1'b1;
         held_valid = 1'b0;
      end
      if (held_valid) begin
         lv[n] = held_level;
         du[n] = held_dur;
         n++;
         held_valid = 1'b0;
      end
      while (left > 0 && n < 4) begin
         chunk = (left > ptcp_pkg::MAX_CHUNK) ? ptcp_pkg::CHUNK_W'(ptcp_pkg::MAX_CHUNK)
                                              : ptcp_pkg::CHUNK_W'(left);
         lv[n] = level_q;
         du[n] = chunk;
         n++;
         left = left - chunk;
      end
      for (i = 0; i + 1 < n; i += 2) begin
         packed_items[count] = '{lv[i], du[i], lv[i+1], du[i+1], 1'b0};
         count++;
      end
      // odd chunk: flush it on the last pulse, else hold it over
      if (i < n) begin
         if (last) begin
            packed_items[count] = '{lv[i], du[i], 1'b0, ptcp_pkg::CHUNK_W'(0), 1'b0};
            count++;
         end else begin
            held_valid = 1'b1;
            held_level = lv[i];
            held_dur = du[i];
         end
      end
      level_q = ~level_q;
      if (last) begin
         if (count > 0)
            packed_items[count-1].last_item = 1'b1;
         train_open = 1'b0;
         held_valid = 1'b0;
         held_level = 1'b0;
         held_dur = '0;
      end
   endtask

   // offer one pulse request and hold it until accepted, then queue its items
   task automatic send_pulse(input logic [ptcp_pkg::DUR_W-1:0] dur, input logic last,
                             input int n_typed, input ptcp_pkg::item_type t0,
                             input ptcp_pkg::item_type t1);
      int count;
      push <= 1'b1;
      req_pulse_duration <= dur;
      req_last_pulse <= last;
      forever begin
         @(posedge clock);
         if (!full)
            break;
         full_cycles++;
      end
      pack_pulse(dur, last, count);
      pulses_sent++;
      if (last)
         trains_closed++;
      if (n_typed == PREDICT) begin
         for (int k = 0; k < count; k++)
            expected_items.insert(expected_items.size(), packed_items[k]);
      end else begin
         if (n_typed > 0)
            expected_items.insert(expected_items.size(), t0);
         if (n_typed > 1)
            expected_items.insert(expected_items.size(), t1);
      end
   endtask

   // drop push and wait until every expected item has been popped
   task automatic wait_drained();
      push <= 1'b0;
      do
         @(posedge clock);
      while (expected_items.size() != 0);
   endtask

   // write start_level once the block is idle
   task automatic write_start_level(input logic value);
      wait_drained();
      // a held-over chunk gives no item, so let the back part settle
      repeat (SETTLE) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      start_level_q = value;
      csr_wr_en <= 1'b0;
   endtask

   // idle the sender now and then, in short bursts
   task automatic maybe_pause();
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   function automatic logic [ptcp_pkg::DUR_W-1:0] pick_duration();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 6))
               0: return 16'd0;
               1: return 16'd1;
               2: return 16'd32766;
               3: return 16'd32767;
               4: return 16'd32768;
               5: return 16'd65534;
               default: return 16'd65535;
            endcase
         end
         1, 2, 3: return ptcp_pkg::DUR_W'($urandom);
         default: return ptcp_pkg::DUR_W'($urandom_range(0, 400));
      endcase
   endfunction

   // result side: check popped items, stall in bursts, hold off on request
   initial begin : rsp_side
      int                  hold_seen;
      int                  hold_left;
      int                  stall_left;
      ptcp_pkg::item_type  want;
      hold_seen = 0;
      hold_left = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) begin
            items_checked++;
            if (expected_items.size() == 0) begin
               error_count++;
               $display("%0t: unexpected item, expected none, got %b %0d %b %0d %b",
                        $time, rsp_first_level, rsp_first_duration,
                        rsp_second_level, rsp_second_duration, rsp_last_item);
            end else begin
               want = expected_items.pop_front();
               if (rsp_first_level !== want.first_level) begin
                  error_count++;
                  $display("%0t: first_level expected %b, got %b", $time,
                           want.first_level, rsp_first_level);
               end
               if (rsp_first_duration !== want.first_duration) begin
                  error_count++;
                  $display("%0t: first_duration expected %0d, got %0d", $time,
                           want.first_duration, rsp_first_duration);
               end
               if (rsp_second_level !== want.second_level) begin
                  error_count++;
                  $display("%0t: second_level expected %b, got %b", $time,
                           want.second_level, rsp_second_level);
               end
               if (rsp_second_duration !== want.second_duration) begin
                  error_count++;
                  $display("%0t: second_duration expected %0d, got %0d", $time,
                           want.second_duration, rsp_second_duration);
               end
               if (rsp_last_item !== want.last_item) begin
                  error_count++;
                  $display("%0t: last_item expected %b, got %b", $time,
                           want.last_item, rsp_last_item);
               end
            end
         end
         // decide pop for the next edge
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // request side: reset, directed table, random trains, wrap-up
   initial begin : req_side
      int   sent;
      int   train_len;
      logic broken;
      logic last;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      foreach (plan[r]) begin
         if (plan[r].kind == ROW_CFG) begin
            write_start_level(plan[r].value[0]);
         end else begin
            send_pulse(plan[r].value, plan[r].last, plan[r].n_typed,
                       plan[r].first_item, plan[r].second_item);
            maybe_pause();
         end
      end

      // random trains, a start level write between phases
      for (int phase = 0; phase < N_PHASES; phase++) begin
         if (phase == 1)
            write_start_level(1'b0);
         else if (phase == 2)
            write_start_level(1'b1);
         else if (phase > 2)
            write_start_level(1'($urandom_range(0, 1)));
         if (phase == N_PHASES - 1)
            quiet_tail <= 1'b1;
         sent = 0;
         while (sent < PHASE_PULSES) begin
            train_len = $urandom_range(1, 8);
            broken = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < train_len; k++) begin
               last = broken ? 1'($urandom_range(0, 1)) : (k == train_len - 1);
               send_pulse(pick_duration(), last, PREDICT, NO_ITEM, NO_ITEM);
               sent++;
               // hold off the receiver while the sender keeps pushing
               if (phase == 2 && sent == 20)
                  hold_asks <= hold_asks + 1;
               maybe_pause();
            end
            if (phase == 3 && $urandom_range(0, 3) == 0)
               wait_drained();
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d pulses in %0d closed trains, checked %0d items.",
               pulses_sent, trains_closed, items_checked);
      $display("Input stalled on full for %0d cycles; start level written both ways.",
               full_cycles);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
